>>> hw/rtl/cfir_pkg.sv
// cfir_pkg: shared constants, job word type and sequencer states for the
// centered saturating FIR filter. No dependencies.
package cfir_pkg;

    localparam int MAX_TAPS_DEF = 16;
    localparam int MAX_RESULTS  = 8;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 4;
    localparam int TW         = 5;
    localparam int SEEN_W     = 5;
    localparam int ACC_W      = 70;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [TW-1:0] FRAC_RESET = 5'd25;
    localparam logic [TW-1:0] TAPS_RESET = 5'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic [SEEN_W-1:0]        sv;
    } job_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MAC,
        S_DRAIN,
        S_OUT,
        S_SHIFT
    } back_state_t;

endpackage

>>> hw/rtl/cfir_if.sv
// cfir_if: valid/ready channel interfaces for input items, results and
// configuration writes. Depends on cfir_pkg.
interface cfir_in_if;
    import cfir_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] value;
    logic                     end_of_signal;

    modport source (output valid, opcode, coef_index, value, end_of_signal, input ready);
    modport sink   (input valid, opcode, coef_index, value, end_of_signal, output ready);
endinterface

interface cfir_out_if;
    import cfir_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered;
    logic                     clamped;
    logic                     final_output;

    modport source (output valid, filtered, clamped, final_output, input ready);
    modport sink   (input valid, filtered, clamped, final_output, output ready);
endinterface

interface cfir_cfg_if;
    import cfir_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/cfir_ram.sv
// cfir_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/cfir_front.sv
// cfir_front: accepts input words, tags samples with their index in the
// signal and queues job words for the back end. Depends on cfir_pkg, cfir_if.
module cfir_front (
    input  logic          clk,
    input  logic          rst_n,
    cfir_in_if.sink       item,
    output cfir_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    import cfir_pkg::*;

    job_t              q_reg [QDEPTH];
    logic [QPW-1:0]    wr_reg;
    logic [QPW-1:0]    rd_reg;
    logic [QCW-1:0]    count_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic              push;
    logic              pop;
    logic [QPW-1:0]    wr_next;
    logic [QPW-1:0]    rd_next;
    job_t              entry;

    assign item.ready = (int'(count_reg) != QDEPTH);
    assign push       = item.valid && item.ready;
    assign job_valid  = (count_reg != '0);
    assign pop        = job_valid && job_ready;
    assign job        = q_reg[rd_reg];

    assign wr_next = (int'(wr_reg) == QDEPTH - 1) ? '0 : wr_reg + QPW'(1);
    assign rd_next = (int'(rd_reg) == QDEPTH - 1) ? '0 : rd_reg + QPW'(1);

    always_comb
    begin
        entry.op    = item.opcode;
        entry.idx   = item.coef_index;
        entry.value = item.value;
        entry.last  = item.end_of_signal;
        entry.sv    = seen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCW'(1);
                2'b01:   count_reg <= count_reg - QCW'(1);
                default: count_reg <= count_reg;
            endcase
            if (push && (item.opcode == OP_SAMPLE))
            begin
                if (item.end_of_signal)
                begin
                    seen_reg <= '0;
                end
                else if (seen_reg != SEEN_MAX)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QDEPTH)
        else $error("job queue count above depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + QCW'(1))
        else $error("job queue push lost");

    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push && (item.opcode == OP_SAMPLE) && item.end_of_signal |=> seen_reg == '0)
        else $error("sample count not cleared at end of signal");
endmodule

>>> hw/rtl/cfir_back.sv
// cfir_back: job sequencer, delay line and coefficient RAMs, one-tap-per-cycle
// MAC, saturation and output register. Depends on cfir_pkg, cfir_if, cfir_ram.
module cfir_back #(
    parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfir_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_ready,
    cfir_cfg_if.sink       cfg,
    cfir_out_if.source     result
);
    import cfir_pkg::*;

    localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW   = $clog2(MAX_TAPS + 1);
    localparam int TCAP = (MAX_TAPS < 2 * MAX_RESULTS) ? MAX_TAPS : 2 * MAX_RESULTS;

    back_state_t state_reg;
    back_state_t state_next;

    job_t                     job_q_reg;
    logic [TW-1:0]            n_reg;
    logic [TW-1:0]            j_reg;
    logic [AW-1:0]            newest_reg;
    logic [FW-1:0]            filled_reg;
    logic [MAX_TAPS-1:0]      cvalid_reg;
    logic [TW-1:0]            frac_reg;
    logic [TW-1:0]            taps_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     cmask1_reg;
    logic                     smask1_reg;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_filt_reg;
    logic                     out_clamp_reg;
    logic                     out_final_reg;

    logic [TW-1:0]            t_eff;
    logic [TW-1:0]            lead;
    logic [TW-1:0]            age;
    logic [AW-1:0]            newest_inc;
    int                       ring_sum;
    logic [AW-1:0]            s_raddr;
    logic [AW-1:0]            c_raddr;
    logic [AW-1:0]            c_waddr;
    logic                     idx_ok;
    logic                     smask;
    logic [TW:0]              sidx;
    logic                     emit;
    logic                     out_free;
    logic                     over;
    logic                     under;
    logic signed [DATA_W-1:0] filt;
    logic signed [DATA_W-1:0] s_rdata;
    logic signed [DATA_W-1:0] c_rdata;
    logic signed [DATA_W-1:0] a_op;
    logic signed [DATA_W-1:0] b_op;
    logic signed [63:0]       prod_full;

    logic                     take;
    logic                     s_we;
    logic signed [DATA_W-1:0] s_wdata;
    logic                     c_we;
    logic                     start_mac;
    logic                     issue;
    logic                     load_out;
    logic                     end_signal;
    logic                     n_inc;

    // effective tap count and lead
    always_comb
    begin
        t_eff = (taps_reg == '0) ? TW'(1) : taps_reg;
        if (int'(t_eff) > TCAP)
        begin
            t_eff = TW'(TCAP);
        end
        lead = t_eff - TW'(1) - (t_eff >> 1);
    end

    // delay line is a ring; age 0 is the newest sample
    assign newest_inc = (int'(newest_reg) == MAX_TAPS - 1) ? '0 : newest_reg + AW'(1);
    assign age        = t_eff - TW'(1) - j_reg;
    assign ring_sum   = int'(newest_reg) + MAX_TAPS - int'(age);
    assign s_raddr    = AW'((ring_sum >= MAX_TAPS) ? ring_sum - MAX_TAPS : ring_sum);
    assign c_raddr    = AW'(j_reg);
    assign c_waddr    = AW'(job.idx);
    assign idx_ok     = int'(job.idx) < MAX_TAPS;
    assign smask      = int'(age) < int'(filled_reg);

    assign sidx     = {1'b0, job_q_reg.sv} + {1'b0, n_reg};
    assign emit     = sidx >= {1'b0, lead};
    assign out_free = !out_valid_reg || result.ready;

    cfir_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_line (
        .clk   (clk),
        .we    (s_we),
        .waddr (newest_inc),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    cfir_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_coef (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (job.value),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        take       = 1'b0;
        s_we       = 1'b0;
        s_wdata    = job.value;
        c_we       = 1'b0;
        start_mac  = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        end_signal = 1'b0;
        n_inc      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    take = 1'b1;
                    if (job.op == OP_LOAD)
                    begin
                        c_we = idx_ok;
                    end
                    else
                    begin
                        s_we       = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (emit)
                begin
                    start_mac  = 1'b1;
                    state_next = S_MAC;
                end
                else if (job_q_reg.last)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAC:
            begin
                issue = 1'b1;
                if (j_reg == t_eff - TW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (job_q_reg.last && (n_reg != lead))
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        end_signal = job_q_reg.last;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHIFT:
            begin
                s_we       = 1'b1;
                s_wdata    = '0;
                n_inc      = 1'b1;
                state_next = S_DECIDE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // saturation
    assign over  = acc_reg > ACC_W'(SAT_MAX);
    assign under = acc_reg < ACC_W'(SAT_MIN);
    assign filt  = over ? SAT_MAX : (under ? SAT_MIN : acc_reg[DATA_W-1:0]);

    assign a_op      = smask1_reg ? s_rdata : '0;
    assign b_op      = cmask1_reg ? c_rdata : '0;
    assign prod_full = a_op * b_op;

    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.filtered     = out_filt_reg;
    assign result.clamped      = out_clamp_reg;
    assign result.final_output = out_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            j_reg         <= '0;
            newest_reg    <= '0;
            filled_reg    <= '0;
            cvalid_reg    <= '0;
            frac_reg      <= FRAC_RESET;
            taps_reg      <= TAPS_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAC_SHIFT: frac_reg <= cfg.data[TW-1:0];
                    CFG_TAP_COUNT:  taps_reg <= cfg.data[TW-1:0];
                    default:        ;
                endcase
            end
            if (c_we)
            begin
                cvalid_reg[c_waddr] <= 1'b1;
            end
            if (take)
            begin
                n_reg <= '0;
            end
            else if (n_inc)
            begin
                n_reg <= n_reg + TW'(1);
            end
            if (start_mac)
            begin
                j_reg <= '0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + TW'(1);
            end
            if (s_we)
            begin
                newest_reg <= newest_inc;
            end
            if (end_signal)
            begin
                filled_reg <= '0;
            end
            else if (s_we && (int'(filled_reg) < MAX_TAPS))
            begin
                filled_reg <= filled_reg + FW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_q_reg <= job;
        end
        cmask1_reg <= cvalid_reg[c_raddr];
        smask1_reg <= smask;
        prod_reg   <= prod_full;
        if (start_mac)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> frac_reg);
        end
        if (load_out)
        begin
            out_filt_reg  <= filt;
            out_clamp_reg <= over || under;
            out_final_reg <= job_q_reg.last && (n_reg == lead);
        end
    end

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> j_reg < t_eff)
        else $error("tap counter past tap count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(filled_reg) <= MAX_TAPS)
        else $error("delay line fill count above depth");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("product stage valid without read stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !load_out)
        else $error("output register overwritten while held");
endmodule

>>> hw/rtl/centered_fir_saturating.sv
// centered_fir_saturating: top level of the centered saturating FIR filter.
// Depends on cfir_pkg, cfir_if, cfir_front, cfir_back.
//
// Channels: item carries one input word per handshake (opcode, coef_index,
// value, end_of_signal); result carries one filtered word (filtered,
// clamped, final_output); cfg writes frac_shift (index 0) or tap_count
// (index 1), and is always ready. Every channel moves a word at a rising
// edge with valid and ready high.
// A coefficient load holds the back end only while it is taken, a non-final
// sample with no output through take and decide. A sample that gives an
// output holds the back end through take, decide, one multiply-accumulate
// per tap of the effective tap count T through a single 32x32 multiplier, a
// drain of the RAM read and product stages and one output load. Each flushed
// output of a final sample adds shift, decide, T taps, drain and load.
// A two-word job queue lets item words be taken while the back end works.
// Reset clears the queue, sample count and delay-line fill, marks all
// coefficients as zero, and loads frac_shift 25 and tap_count 5. No clearing
// pass is needed. When result is stalled the finished word holds in the
// output register and the back end waits; the queue then fills and item
// ready drops.
module centered_fir_saturating #(
    parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    cfir_in_if.sink     item,
    cfir_out_if.source  result,
    cfir_cfg_if.sink    cfg
);
    import cfir_pkg::*;

    job_t job;
    logic job_valid;
    logic job_ready;

    cfir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    cfir_back #(.MAX_TAPS(MAX_TAPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .cfg       (cfg),
        .result    (result)
    );
endmodule
